// ===== rtl/assert_macros.svh =====
// assertion macros shared by the text overlay rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// implication with a fixed delay in clock cycles
`define ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/stgr_pkg.sv =====
// types, constants, font table and code mapping for the text overlay
// no dependencies
package stgr_pkg;

  localparam int DEF_TEXT_SLOTS = 24;
  localparam int DEF_SCALE      = 8;

  localparam int GLYPH_COUNT = 37;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int CELL_COLS   = 6;
  localparam int COLON_GLYPH = 36;
  localparam int RECIP_SHIFT = 24;

  localparam logic [31:0] COLOR_LIT  = 32'hffffffff;
  localparam logic [31:0] COLOR_DARK = 32'hff000000;

  localparam logic [7:0] CODE_ZERO  = 8'h30;
  localparam logic [7:0] CODE_NINE  = 8'h39;
  localparam logic [7:0] CODE_COLON = 8'h3a;
  localparam logic [7:0] CODE_A     = 8'h41;
  localparam logic [7:0] CODE_Z     = 8'h5a;

  localparam int CFG_ADDR_W = 4;

  localparam logic [11:0] RST_ORIGIN_X    = 12'd64;
  localparam logic [11:0] RST_ORIGIN_Y    = 12'd100;
  localparam logic [4:0]  RST_TEXT_LENGTH = 5'd0;

  typedef enum logic [1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_TEXT_LENGTH = 2'd2
  } reg_index_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [4:0]  slot;
    logic [7:0]  char_code;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic        lit;
    logic [31:0] pixel_word;
  } out_item_t;

  typedef struct packed {
    logic        vld;
    logic        query;
    logic [4:0]  slot;
    logic [7:0]  code;
    logic        draw_ok;
    logic [11:0] cell_idx;
    logic [2:0]  row;
    logic [2:0]  col;
  } geom_t;

  typedef struct packed {
    logic       vld;
    logic       draw_ok;
    logic [2:0] row;
    logic [2:0] col;
    logic [7:0] code;
  } lookup_t;

  localparam logic [5:0] GLYPH_NONE = 6'(GLYPH_COUNT);

  function automatic logic [5:0] glyph_of(logic [7:0] code);
    logic [5:0] g;
    priority if (code >= CODE_ZERO && code <= CODE_NINE) begin
      g = 6'(code - CODE_ZERO);
    end else if (code >= CODE_A && code <= CODE_Z) begin
      g = 6'(code - CODE_A) + 6'd10;
    end else if (code == CODE_COLON) begin
      g = 6'(COLON_GLYPH);
    end else begin
      g = GLYPH_NONE;
    end
    return g;
  endfunction

  // top row in the high bits, leftmost pixel in the high bit of each row
  function automatic logic [4:0] font_row(logic [5:0] g, logic [2:0] row);
    logic [34:0] rows;
    logic [34:0] sh;
    unique case (g)
      6'd0:  rows = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      6'd1:  rows = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd2:  rows = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      6'd3:  rows = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      6'd4:  rows = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      6'd5:  rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      6'd6:  rows = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      6'd7:  rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      6'd8:  rows = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      6'd9:  rows = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      6'd10: rows = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd11: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      6'd12: rows = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      6'd13: rows = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      6'd14: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      6'd15: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd16: rows = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      6'd17: rows = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      6'd18: rows = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      6'd19: rows = {5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12};
      6'd20: rows = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      6'd21: rows = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      6'd22: rows = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      6'd23: rows = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      6'd24: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd25: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      6'd26: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      6'd27: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      6'd28: rows = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      6'd29: rows = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      6'd30: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      6'd31: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      6'd32: rows = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      6'd33: rows = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      6'd34: rows = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      6'd35: rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      6'd36: rows = {5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0};
      default: rows = '0;
    endcase
    sh = rows >> (5 * (3'd6 - row));
    return sh[4:0];
  endfunction

endpackage

// ===== rtl/scaled_text_glyph_rasterizer.sv =====
// One-line text overlay with a built-in 5x7 font. busy stays low, so an item
// is taken on every clock with start high; a query's result appears on strobe
// for one cycle, and the receiver cannot stall. A query passes through four
// geometry register stages (reciprocal multiply, quotient correction), the
// text memory's registered read and the result register. Writes to text
// slots pass through the same stages, so slot writes and lookups stay in
// order. Slot contents read as zero after reset at once; there is no
// clearing pass.
// depends on stgr_pkg, stgr_geom, stgr_text_mem, stgr_glyph, assert_macros.svh
`include "assert_macros.svh"

module scaled_text_glyph_rasterizer #(
  parameter int TEXT_SLOTS = stgr_pkg::DEF_TEXT_SLOTS,
  parameter int SCALE      = stgr_pkg::DEF_SCALE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  stgr_pkg::in_item_t                  cmd,
  output logic                                strobe,
  output stgr_pkg::out_item_t                 result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stgr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import stgr_pkg::*;

  logic [11:0] origin_x, origin_y;
  logic [4:0]  text_length;
  logic        cfg_wr;
  logic        cmd_vld;
  reg_index_t  reg_idx;
  geom_t       geom;
  lookup_t     lookup;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cmd_vld = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= RST_ORIGIN_X;
      origin_y    <= RST_ORIGIN_Y;
      text_length <= RST_TEXT_LENGTH;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_X:    origin_x    <= pwdata[11:0];
        REG_ORIGIN_Y:    origin_y    <= pwdata[11:0];
        REG_TEXT_LENGTH: text_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:    prdata = 32'(origin_x);
      REG_ORIGIN_Y:    prdata = 32'(origin_y);
      REG_TEXT_LENGTH: prdata = 32'(text_length);
      default:         prdata = '0;
    endcase
  end

  stgr_geom #(
    .SCALE      (SCALE),
    .TEXT_SLOTS (TEXT_SLOTS)
  ) u_geom (
    .clk         (clk),
    .rst         (rst),
    .cmd_vld     (cmd_vld),
    .cmd         (cmd),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .text_length (text_length),
    .geom        (geom)
  );

  stgr_text_mem #(
    .TEXT_SLOTS (TEXT_SLOTS)
  ) u_text_mem (
    .clk    (clk),
    .rst    (rst),
    .geom   (geom),
    .lookup (lookup)
  );

  stgr_glyph u_glyph (
    .clk    (clk),
    .rst    (rst),
    .lookup (lookup),
    .strobe (strobe),
    .result (result)
  );

  // every query transfer yields exactly one result
  `ASSERT_DELAY(a_query_result, clk, rst, cmd_vld && cmd.operation == OP_QUERY, 6, strobe)
  `ASSERT_DELAY(a_write_silent, clk, rst, cmd_vld && cmd.operation == OP_WRITE, 6, !strobe)
  `ASSERT_IMPL(a_word_match, clk, rst, strobe, result.pixel_word == (result.lit ? COLOR_LIT : COLOR_DARK))

endmodule

// ===== rtl/stgr_geom.sv =====
// screen-to-cell geometry pipeline: cell index, glyph row and column per item
// depends on stgr_pkg
module stgr_geom #(
  parameter int SCALE      = stgr_pkg::DEF_SCALE,
  parameter int TEXT_SLOTS = stgr_pkg::DEF_TEXT_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_vld,
  input  stgr_pkg::in_item_t cmd,
  input  logic [11:0]        origin_x,
  input  logic [11:0]        origin_y,
  input  logic [4:0]         text_length,
  output stgr_pkg::geom_t    geom
);
  import stgr_pkg::*;

  localparam int          CELL_W = CELL_COLS * SCALE;
  localparam logic [23:0] RECIP  = 24'((2 ** RECIP_SHIFT) / CELL_W);

  logic        s1_vld, s1_query, s1_in;
  logic [4:0]  s1_slot;
  logic [7:0]  s1_code;
  logic [11:0] s1_dx, s1_dy;

  logic        s2_vld, s2_query, s2_in;
  logic [4:0]  s2_slot;
  logic [7:0]  s2_code;
  logic [11:0] s2_dx, s2_q;
  logic [2:0]  s2_row;

  logic        s3_vld, s3_query, s3_in;
  logic [4:0]  s3_slot;
  logic [7:0]  s3_code;
  logic [11:0] s3_dx, s3_q, s3_qd;
  logic [2:0]  s3_row;

  logic [35:0] prod;
  logic [2:0]  row_cnt;
  logic        row_ok;
  logic [18:0] qd_full;
  logic [11:0] r_raw, r_fix, cell_fix;
  logic        over;
  logic [2:0]  col_cnt;
  logic        col_ok, cell_ok;

  // estimated quotient is the true one or one below it
  assign prod = 36'(s1_dx) * 36'(RECIP);

  always_comb begin
    row_cnt = '0;
    for (int k = 1; k < GLYPH_ROWS; k++) begin
      if (s1_dy >= 12'(k * SCALE)) row_cnt = row_cnt + 3'd1;
    end
  end
  assign row_ok = s1_dy < 12'(GLYPH_ROWS * SCALE);

  assign qd_full = 19'(s2_q) * 19'(CELL_W);

  assign r_raw    = s3_dx - s3_qd;
  assign over     = r_raw >= 12'(CELL_W);
  assign r_fix    = over ? r_raw - 12'(CELL_W) : r_raw;
  assign cell_fix = over ? s3_q + 12'd1 : s3_q;

  always_comb begin
    col_cnt = '0;
    for (int k = 1; k < GLYPH_COLS; k++) begin
      if (r_fix >= 12'(k * SCALE)) col_cnt = col_cnt + 3'd1;
    end
  end
  assign col_ok  = r_fix < 12'(GLYPH_COLS * SCALE);
  assign cell_ok = (cell_fix < 12'(text_length)) && (cell_fix < 12'(TEXT_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      geom.vld <= 1'b0;
    end else begin
      s1_vld   <= cmd_vld;
      s2_vld   <= s1_vld;
      s3_vld   <= s2_vld;
      geom.vld <= s3_vld;
    end
    s1_query <= cmd.operation == OP_QUERY;
    s1_slot  <= cmd.slot;
    s1_code  <= cmd.char_code;
    s1_in    <= (cmd.pixel_x >= origin_x) && (cmd.pixel_y >= origin_y);
    s1_dx    <= cmd.pixel_x - origin_x;
    s1_dy    <= cmd.pixel_y - origin_y;

    s2_query <= s1_query;
    s2_slot  <= s1_slot;
    s2_code  <= s1_code;
    s2_in    <= s1_in && row_ok;
    s2_dx    <= s1_dx;
    s2_q     <= prod[35:RECIP_SHIFT];
    s2_row   <= row_cnt;

    s3_query <= s2_query;
    s3_slot  <= s2_slot;
    s3_code  <= s2_code;
    s3_in    <= s2_in;
    s3_dx    <= s2_dx;
    s3_q     <= s2_q;
    s3_qd    <= qd_full[11:0];
    s3_row   <= s2_row;

    geom.query    <= s3_query;
    geom.slot     <= s3_slot;
    geom.code     <= s3_code;
    geom.draw_ok  <= s3_in && col_ok && cell_ok;
    geom.cell_idx <= cell_fix;
    geom.row      <= s3_row;
    geom.col      <= col_cnt;
  end

endmodule

// ===== rtl/stgr_text_mem.sv =====
// text slot memory with per-slot valid bits; writes and lookups share one stage
// depends on stgr_pkg
module stgr_text_mem #(
  parameter int TEXT_SLOTS = stgr_pkg::DEF_TEXT_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  stgr_pkg::geom_t   geom,
  output stgr_pkg::lookup_t lookup
);
  import stgr_pkg::*;

  localparam int ADDR_W = (TEXT_SLOTS > 1) ? $clog2(TEXT_SLOTS) : 1;

  logic [7:0]            mem [TEXT_SLOTS];
  logic [TEXT_SLOTS-1:0] slot_vld;
  logic                  wr;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [7:0]            rd_data;
  logic                  rd_vld;
  logic                  lk_vld, lk_draw;
  logic [2:0]            lk_row, lk_col;

  assign wr      = geom.vld && !geom.query && (7'(geom.slot) < 7'(TEXT_SLOTS));
  assign wr_addr = ADDR_W'(geom.slot);
  assign rd_addr = geom.draw_ok ? ADDR_W'(geom.cell_idx) : '0;

  always_ff @(posedge clk) begin
    if (wr) mem[wr_addr] <= geom.code;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      lk_vld   <= 1'b0;
    end else begin
      if (wr) slot_vld[wr_addr] <= 1'b1;
      lk_vld <= geom.vld && geom.query;
    end
    rd_vld  <= slot_vld[rd_addr];
    lk_draw <= geom.draw_ok;
    lk_row  <= geom.row;
    lk_col  <= geom.col;
  end

  // never-written slots read as code zero
  assign lookup.vld     = lk_vld;
  assign lookup.draw_ok = lk_draw;
  assign lookup.row     = lk_row;
  assign lookup.col     = lk_col;
  assign lookup.code    = rd_vld ? rd_data : 8'd0;

endmodule

// ===== rtl/stgr_glyph.sv =====
// glyph decode, font lookup and registered result
// depends on stgr_pkg
module stgr_glyph (
  input  logic                clk,
  input  logic                rst,
  input  stgr_pkg::lookup_t   lookup,
  output logic                strobe,
  output stgr_pkg::out_item_t result
);
  import stgr_pkg::*;

  logic [5:0] g;
  logic [4:0] bits;
  logic       on;

  assign g    = glyph_of(lookup.code);
  assign bits = font_row(g, lookup.row);
  assign on   = lookup.draw_ok && (g != GLYPH_NONE) && bits[3'(3'd4 - lookup.col)];

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= lookup.vld;
    end
    result.lit        <= on;
    result.pixel_word <= on ? COLOR_LIT : COLOR_DARK;
  end

endmodule

// ===== verif/scaled_text_glyph_rasterizer_tb.sv =====
// self-checking testbench for the scaled 5x7 text overlay: slot writes and pixel queries
// with a built-in pixel predictor, apb register setup between phases and random idling
// depends on stgr_pkg and the scaled_text_glyph_rasterizer rtl
module scaled_text_glyph_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stgr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CELL_PIX = CELL_COLS * DEF_SCALE;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [GLYPH_COUNT*GLYPH_ROWS*GLYPH_COLS-1:0] FONT_BITS = {
    5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14,
    5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14,
    5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31,
    5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30,
    5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2,
    5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30,
    5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14,
    5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8,
    5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14,
    5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14,
    5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17,
    5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30,
    5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14,
    5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30,
    5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31,
    5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16,
    5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15,
    5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17,
    5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14,
    5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12,
    5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17,
    5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31,
    5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17,
    5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17,
    5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14,
    5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16,
    5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13,
    5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17,
    5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30,
    5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4,
    5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10,
    5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17,
    5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4,
    5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31,
    5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_item_t              cmd;
  logic                  strobe;
  out_item_t             result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  logic [11:0] org_x;
  logic [11:0] org_y;
  logic [4:0]  text_len;
  logic [7:0]  slot_codes [DEF_TEXT_SLOTS];
  out_item_t   pending_pixels [$];

  int unsigned idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned writes_sent;
  int unsigned queries_sent;
  int unsigned lit_seen;
  int unsigned settings_used;

  scaled_text_glyph_rasterizer u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .strobe  (strobe),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  function automatic int unsigned code_glyph_index(logic [7:0] code);
    if (code >= CODE_ZERO && code <= CODE_NINE) return code - CODE_ZERO;
    if (code >= CODE_A && code <= CODE_Z) return 10 + (code - CODE_A);
    if (code == CODE_COLON) return COLON_GLYPH;
    return GLYPH_COUNT;
  endfunction

  function automatic logic [7:0] font_code(int unsigned g);
    if (g < 10) return 8'(CODE_ZERO + g);
    if (g < COLON_GLYPH) return 8'(CODE_A + (g - 10));
    return CODE_COLON;
  endfunction

  function automatic logic glyph_pixel_on(logic [11:0] px, logic [11:0] py);
    int unsigned dx, dy, cell_no, col, row, drawn, g, lo;
    if (px < org_x || py < org_y) return 1'b0;
    dx = px - org_x;
    dy = py - org_y;
    row = dy / DEF_SCALE;
    if (row >= GLYPH_ROWS) return 1'b0;
    cell_no = dx / CELL_PIX;
    col = (dx % CELL_PIX) / DEF_SCALE;
    if (col >= GLYPH_COLS) return 1'b0;
    drawn = (text_len < DEF_TEXT_SLOTS) ? text_len : DEF_TEXT_SLOTS;
    if (cell_no >= drawn) return 1'b0;
    g = code_glyph_index(slot_codes[cell_no]);
    if (g >= GLYPH_COUNT) return 1'b0;
    lo = (GLYPH_COUNT * GLYPH_ROWS - 1 - (g * GLYPH_ROWS + row)) * GLYPH_COLS;
    return FONT_BITS[lo + (GLYPH_COLS - 1 - col)];
  endfunction

  function automatic in_item_t write_item(logic [4:0] slot, logic [7:0] code);
    in_item_t it;
    it.operation = OP_WRITE;
    it.slot = slot;
    it.char_code = code;
    it.pixel_x = 12'($urandom);
    it.pixel_y = 12'($urandom);
    return it;
  endfunction

  function automatic in_item_t query_item(logic [11:0] px, logic [11:0] py);
    in_item_t it;
    it.operation = OP_QUERY;
    it.slot = 5'($urandom);
    it.char_code = 8'($urandom);
    it.pixel_x = px;
    it.pixel_y = py;
    return it;
  endfunction

  // mostly queries aimed at the drawn text, some slot writes, some noise
  function automatic in_item_t random_item();
    int unsigned pick, drawn, span;
    logic [7:0] code;
    pick = $urandom_range(99);
    drawn = (text_len < DEF_TEXT_SLOTS) ? text_len : DEF_TEXT_SLOTS;
    span = ((drawn == 0) ? 1 : drawn) * CELL_PIX + DEF_SCALE - 1;
    if (pick < 22) begin
      code = ($urandom_range(9) < 6) ? font_code($urandom_range(GLYPH_COUNT - 1))
                                      : 8'($urandom);
      return write_item(5'($urandom_range(DEF_TEXT_SLOTS - 1)), code);
    end else if (pick < 27) begin
      return write_item(5'($urandom), 8'($urandom));
    end else if (pick < 88) begin
      return query_item(12'(org_x + $urandom_range(span)),
                        12'(org_y + $urandom_range(GLYPH_ROWS * DEF_SCALE + 7)));
    end
    return query_item(12'($urandom), 12'($urandom));
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
    error_count++;
  endtask

  task automatic send_cmd(input in_item_t it);
    out_item_t want;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      cmd <= in_item_t'({$urandom, $urandom});
      @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= it;
    do @(posedge clk); while (busy);
    if (it.operation == OP_WRITE) begin
      if (it.slot < DEF_TEXT_SLOTS) slot_codes[it.slot] = it.char_code;
      writes_sent++;
    end else begin
      want.lit = glyph_pixel_on(it.pixel_x, it.pixel_y);
      want.pixel_word = want.lit ? COLOR_LIT : COLOR_DARK;
      pending_pixels.push_back(want);
      queries_sent++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ORIGIN_X:    org_x = data[11:0];
      REG_ORIGIN_Y:    org_y = data[11:0];
      REG_TEXT_LENGTH: text_len = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [11:0] ox, input logic [11:0] oy, input logic [4:0] len);
    wait_drained();
    apb_write(REG_ORIGIN_X, {$urandom_range(32'hfffff) << 12} | ox);
    apb_write(REG_ORIGIN_Y, {$urandom_range(32'hfffff) << 12} | oy);
    apb_write(REG_TEXT_LENGTH, {$urandom_range(32'h7ffffff) << 5} | len);
    settings_used++;
  endtask

  task automatic test_glyph_corners();
    int unsigned x0, y0;
    idle_pct = 0;
    x0 = RST_ORIGIN_X;
    y0 = RST_ORIGIN_Y;
    send_cmd(query_item(12'(x0), 12'(y0)));
    send_cmd(write_item(5'd0, CODE_Z));
    send_cmd(write_item(5'd1, CODE_ZERO));
    send_cmd(write_item(5'd2, CODE_NINE));
    send_cmd(write_item(5'd3, CODE_A));
    send_cmd(write_item(5'd4, CODE_COLON));
    send_cmd(write_item(5'd5, 8'h00));
    send_cmd(write_item(5'd6, 8'hff));
    send_cmd(write_item(5'd23, 8'h4d));
    send_cmd(write_item(5'd24, CODE_Z));
    send_cmd(write_item(5'd31, CODE_Z));
    wait_drained();
    apb_write(REG_TEXT_LENGTH, 32'hffff_ffff);
    settings_used++;
    send_cmd(query_item(12'(x0), 12'(y0)));
    send_cmd(query_item(12'(x0 + 5 * DEF_SCALE), 12'(y0)));
    send_cmd(query_item(12'(x0 - 1), 12'(y0)));
    send_cmd(query_item(12'(x0), 12'(y0 - 1)));
    send_cmd(query_item(12'(x0), 12'(y0 + GLYPH_ROWS * DEF_SCALE)));
    send_cmd(query_item(12'(x0 + CELL_PIX + 4 * DEF_SCALE + 7), 12'(y0 + 6 * DEF_SCALE + 7)));
    send_cmd(query_item(12'(x0 + 4 * CELL_PIX + 2 * DEF_SCALE), 12'(y0 + DEF_SCALE)));
    send_cmd(query_item(12'(x0 + 5 * CELL_PIX), 12'(y0)));
    send_cmd(query_item(12'(x0 + 23 * CELL_PIX), 12'(y0)));
    send_cmd(query_item(12'(x0 + 24 * CELL_PIX), 12'(y0)));
    send_cmd(query_item(12'hfff, 12'hfff));
    send_cmd(query_item(12'h000, 12'h000));
  endtask

  task automatic test_unknown_register();
    wait_drained();
    apb_write(REG_UNUSED, $urandom);
    repeat (8) send_cmd(random_item());
  endtask

  task automatic test_drain_pause();
    configure(12'd0, 12'd0, 5'd24);
    idle_pct = 27;
    repeat (6) begin
      repeat (6) send_cmd(random_item());
      wait_drained();
    end
  endtask

  task automatic test_random_phases();
    logic [11:0] ox, oy;
    logic [4:0] len;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin ox = 12'd0; oy = 12'd0; len = 5'd24; end
        1: begin ox = 12'hfff; oy = 12'hfff; len = 5'd31; end
        2: begin ox = 12'hfff - 12'($urandom_range(CELL_PIX)); oy = 12'd0; len = 5'd0; end
        default: begin
          ox = 12'($urandom_range(($urandom_range(3) == 0) ? 4095 : 2000));
          oy = 12'($urandom);
          len = 5'($urandom);
        end
      endcase
      configure(ox, oy, len);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 86 : 27);
      repeat (250) send_cmd(random_item());
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && strobe) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, lit/pixel_word", {31'd0, result.lit},
                        result.pixel_word);
      end else begin
        want = pending_pixels.pop_front();
        if (result.lit !== want.lit) report_mismatch("lit", {31'd0, result.lit}, {31'd0, want.lit});
        if (result.pixel_word !== want.pixel_word)
          report_mismatch("pixel_word", result.pixel_word, want.pixel_word);
        if (want.lit) lit_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pixels.size());
      $display("scaled_text_glyph_rasterizer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    org_x = RST_ORIGIN_X;
    org_y = RST_ORIGIN_Y;
    text_len = RST_TEXT_LENGTH;
    foreach (slot_codes[i]) slot_codes[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_glyph_corners();
    test_unknown_register();
    test_drain_pause();
    test_random_phases();
    wait_drained();

    $display("covered %0d slot writes and %0d pixel queries (%0d lit)", writes_sent,
             queries_sent, lit_seen);
    $display("over %0d register settings with origin and length extremes", settings_used);
    if (error_count == 0) begin
      $display("scaled_text_glyph_rasterizer_tb: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("scaled_text_glyph_rasterizer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== scaled_text_glyph_rasterizer.f =====
+incdir+rtl
rtl/stgr_pkg.sv
rtl/stgr_geom.sv
rtl/stgr_text_mem.sv
rtl/stgr_glyph.sv
rtl/scaled_text_glyph_rasterizer.sv
verif/scaled_text_glyph_rasterizer_tb.sv
